[sv/pbga_pkg.sv]
// shared types, widths and helpers for the piece block gap allocator
package pbga_pkg;

    localparam int OFFW            = 26;   // byte offset inside a piece
    localparam int SIZEW           = 18;   // range length
    localparam int PLW             = 27;   // piece length register
    localparam int PBGA_MAX_RANGES = 64;

    localparam logic [PLW-1:0] PL_RESET     = 27'd262144;
    localparam logic [PLW-1:0] OFFSET_LIMIT = 27'h400_0000;

    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_MARK    = 2'd1,
        OP_DISCARD = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_INSERT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [OFFW-1:0]  start;
        logic [SIZEW-1:0] length;
        logic             received;
    } t_entry;

    // length of a gap, capped at the size asked for
    function automatic logic [SIZEW-1:0] clip_len(input logic [PLW-1:0]  span,
                                                  input logic [SIZEW-1:0] want);
        logic [PLW-1:0] want_w;
        want_w   = {{(PLW-SIZEW){1'b0}}, want};
        clip_len = (span > want_w) ? want : span[SIZEW-1:0];
    endfunction

endpackage

[sv/piece_block_gap_allocator.sv]
// top level of the piece block gap allocator: range list in memory, walk and insert sequencer
//
// Keeps the ranges handed out inside one piece as a list sorted by start offset.
// Input channel (i_in_valid / o_in_stall) takes one beat per operation: request a range
// of up to i_request_size bytes, mark the range starting at i_range_start as received,
// or discard the whole list. Output channel (o_out_valid / i_out_stall) returns one beat
// per operation with the grant and the piece-complete flag after the operation.
// The piece length is written through i_cfg_valid / o_cfg_ready / i_cfg_data; the user is to
// write it only while the block is idle, and the block itself has no check for this; the port is always ready.
// Every operation except discard walks the list through the entry memory (one write
// and one read port), one entry a cycle. A granted request stops its walk at the
// gap and then shifts the entries above the new one up by one slot, again one
// entry a cycle. Discard skips the walk. One item is in work at a time; o_in_stall
// is high from acceptance until the result has been placed in the output register.
// The output register lets the next beat be accepted while a result still waits;
// a stalled receiver only holds the block once the following result is ready.
// Reset (synchronous, active low) empties the list, sets the piece length to 262144
// and drops o_out_valid. The entry memory itself is not cleared: only entries below
// the list count are ever read.
module piece_block_gap_allocator
    import pbga_pkg::*;
#(
    parameter int MAX_RANGES = PBGA_MAX_RANGES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [PLW-1:0]    i_cfg_data,
    // operation beats
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_operation,
    input  logic [SIZEW-1:0]  i_request_size,
    input  logic [OFFW-1:0]   i_range_start,
    // result beats
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_granted,
    output logic [OFFW-1:0]   o_grant_start,
    output logic [SIZEW-1:0]  o_grant_length,
    output logic              o_piece_complete
);

    localparam int IDXW = $clog2(MAX_RANGES);
    localparam int CW   = $clog2(MAX_RANGES + 1);

    // control state
    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_rd_idx, n_rd_idx;      // next entry to read
    logic             r_vld, n_vld;            // memory read data valid this cycle
    logic [IDXW-1:0]  r_pipe_idx, n_pipe_idx;  // entry the read data belongs to
    logic             r_out_valid, n_out_valid;
    logic [PLW-1:0]   r_piece_length;

    // per-item work registers
    logic             r_req_en, n_req_en;
    logic             r_mark_en, n_mark_en;
    logic             r_marked, n_marked;
    logic             r_found, n_found;
    logic             r_ok, n_ok;
    logic             r_cov, n_cov;
    logic [PLW-1:0]   r_cur, n_cur;            // gap search cursor
    logic [PLW-1:0]   r_pos, n_pos;            // end of contiguous received run
    logic [SIZEW-1:0] r_want, n_want;
    logic [OFFW-1:0]  r_mstart, n_mstart;
    logic [OFFW-1:0]  r_gs, n_gs;
    logic [SIZEW-1:0] r_gl, n_gl;

    // result register
    logic             r_granted, n_granted;
    logic [OFFW-1:0]  r_grant_start, n_grant_start;
    logic [SIZEW-1:0] r_grant_length, n_grant_length;
    logic             r_complete, n_complete;

    // entry memory
    t_entry           r_mem [MAX_RANGES];
    t_entry           r_rd_data;
    logic             mem_re, mem_we;
    logic [IDXW-1:0]  mem_raddr, mem_waddr;
    t_entry           mem_wdata;

    // datapath helpers
    logic [PLW-1:0]   w_eff;
    logic [PLW-1:0]   w_ent_start;
    logic [PLW-1:0]   w_ent_end;
    logic [PLW-1:0]   w_gap_span;
    logic [PLW-1:0]   w_tail_span;
    logic             w_match;
    logic [CW-1:0]    w_dec;
    t_entry           w_new;
    logic             in_beat;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_beat     = i_in_valid && (r_state == S_IDLE);

    // piece length above the offset range counts as the full offset range
    assign w_eff       = (r_piece_length > OFFSET_LIMIT) ? OFFSET_LIMIT : r_piece_length;
    assign w_ent_start = {1'b0, r_rd_data.start};
    assign w_ent_end   = w_ent_start + {{(PLW-SIZEW){1'b0}}, r_rd_data.length};
    assign w_gap_span  = w_ent_start - r_cur;
    assign w_tail_span = w_eff - r_cur;
    assign w_match     = r_mark_en && !r_marked && (r_rd_data.start == r_mstart);
    assign w_dec       = r_rd_idx - CW'(1);
    assign w_new       = '{start: r_gs, length: r_gl, received: 1'b0};

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_rd_idx       = r_rd_idx;
        n_vld          = 1'b0;
        n_pipe_idx     = r_pipe_idx;
        n_out_valid    = r_out_valid && i_out_stall;
        n_req_en       = r_req_en;
        n_mark_en      = r_mark_en;
        n_marked       = r_marked;
        n_found        = r_found;
        n_ok           = r_ok;
        n_cov          = r_cov;
        n_cur          = r_cur;
        n_pos          = r_pos;
        n_want         = r_want;
        n_mstart       = r_mstart;
        n_gs           = r_gs;
        n_gl           = r_gl;
        n_granted      = r_granted;
        n_grant_start  = r_grant_start;
        n_grant_length = r_grant_length;
        n_complete     = r_complete;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_raddr      = r_rd_idx[IDXW-1:0];
        mem_waddr      = r_pipe_idx;
        mem_wdata      = r_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_want    = i_request_size;
                    n_mstart  = i_range_start;
                    n_req_en  = (i_operation == OP_REQUEST) && (r_count < CW'(MAX_RANGES))
                                && (i_request_size != '0);
                    n_mark_en = (i_operation == OP_MARK);
                    n_marked  = 1'b0;
                    n_found   = 1'b0;
                    n_ok      = 1'b1;
                    n_cur     = '0;
                    n_pos     = '0;
                    n_rd_idx  = '0;
                    if (i_operation == OP_DISCARD) begin
                        n_count = '0;
                        n_cov   = (w_eff == '0);
                        n_state = S_DONE;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end

            S_WALK: begin
                // keep one read in flight ahead of the entry being looked at
                if (r_rd_idx != r_count) begin
                    mem_re     = 1'b1;
                    mem_raddr  = r_rd_idx[IDXW-1:0];
                    n_rd_idx   = r_rd_idx + CW'(1);
                    n_vld      = 1'b1;
                    n_pipe_idx = r_rd_idx[IDXW-1:0];
                end
                if (r_vld) begin
                    if (r_req_en && (r_cur < w_ent_start)) begin
                        // first gap found before this entry
                        n_found  = 1'b1;
                        n_gs     = r_cur[OFFW-1:0];
                        n_gl     = clip_len(w_gap_span, r_want);
                        n_cov    = 1'b0;
                        n_rd_idx = r_count;
                        n_vld    = 1'b0;
                        n_state  = S_INSERT;
                    end else begin
                        if (r_req_en) begin
                            n_cur = w_ent_end;
                        end
                        if (w_match) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_pipe_idx;
                            mem_wdata = '{start: r_rd_data.start, length: r_rd_data.length,
                                          received: 1'b1};
                            n_marked  = 1'b1;
                        end
                        if (r_ok && (w_ent_start == r_pos)
                                && (r_rd_data.received || w_match)) begin
                            n_pos = w_ent_end;
                        end else begin
                            n_ok = 1'b0;
                        end
                    end
                end else if (r_rd_idx == r_count) begin
                    // whole list seen
                    if (r_req_en && (w_eff > r_cur)) begin
                        n_found  = 1'b1;
                        n_gs     = r_cur[OFFW-1:0];
                        n_gl     = clip_len(w_tail_span, r_want);
                        n_cov    = 1'b0;
                        n_rd_idx = r_count;
                        n_state  = S_INSERT;
                    end else begin
                        n_cov   = r_ok && (r_pos == w_eff);
                        n_state = S_DONE;
                    end
                end
            end

            S_INSERT: begin
                // walk down from the top, moving larger starts up one slot
                if (r_rd_idx != '0) begin
                    mem_re     = 1'b1;
                    mem_raddr  = w_dec[IDXW-1:0];
                    n_rd_idx   = w_dec;
                    n_vld      = 1'b1;
                    n_pipe_idx = w_dec[IDXW-1:0];
                end
                if (r_vld) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pipe_idx + IDXW'(1);
                    if (r_gs < r_rd_data.start) begin
                        mem_wdata = r_rd_data;
                    end else begin
                        mem_wdata = w_new;
                        n_count   = r_count + CW'(1);
                        n_vld     = 1'b0;
                        n_state   = S_DONE;
                    end
                end else if (r_rd_idx == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = w_new;
                    n_count   = r_count + CW'(1);
                    n_state   = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid    = 1'b1;
                    n_granted      = r_found;
                    n_grant_start  = r_found ? r_gs : '0;
                    n_grant_length = r_found ? r_gl : '0;
                    n_complete     = r_cov;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_rd_idx       <= '0;
            r_vld          <= 1'b0;
            r_out_valid    <= 1'b0;
            r_piece_length <= PL_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_piece_length <= i_cfg_data;
            end
        end
    end

    // work and result registers
    always_ff @(posedge i_clk) begin
        r_pipe_idx     <= n_pipe_idx;
        r_req_en       <= n_req_en;
        r_mark_en      <= n_mark_en;
        r_marked       <= n_marked;
        r_found        <= n_found;
        r_ok           <= n_ok;
        r_cov          <= n_cov;
        r_cur          <= n_cur;
        r_pos          <= n_pos;
        r_want         <= n_want;
        r_mstart       <= n_mstart;
        r_gs           <= n_gs;
        r_gl           <= n_gl;
        r_granted      <= n_granted;
        r_grant_start  <= n_grant_start;
        r_grant_length <= n_grant_length;
        r_complete     <= n_complete;
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_granted        = r_granted;
    assign o_grant_start    = r_grant_start;
    assign o_grant_length   = r_grant_length;
    assign o_piece_complete = r_complete;

endmodule
